[hdl/bank_of_stacks_leftmost_fill_top_macros.svh]
// assertion macros used by the checker file of the stack bank
`ifndef BANK_OF_STACKS_LEFTMOST_FILL_TOP_MACROS_SVH
`define BANK_OF_STACKS_LEFTMOST_FILL_TOP_MACROS_SVH

// antecedent in one cycle implies consequent in the same cycle
`define BOSLF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define BOSLF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/boslf_pkg.sv]
// package with item types and codes of the stack bank
package boslf_pkg;

   // operation codes
   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_POP_AT = 2'd2;

   // result status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // capacity register after reset
   localparam logic [4:0] CAP_RESET = 5'd16;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] push_value;
      logic [3:0]  stack_index;
   } req_type;

   typedef struct packed {
      logic [31:0] pop_value;
      logic [1:0]  status;
      logic [3:0]  stack_touched;
   } rsp_type;

endpackage

[hdl/bank_of_stacks_leftmost_fill_top.sv]
// top level of the bank of plate stacks with leftmost fill
//
// Usage:
//   req channel (req_valid/req_ready/req_item) takes one operation per item:
//   push to the leftmost stack that is not full, pop from the rightmost
//   nonempty stack, or pop from the stack named in stack_index.
//   rsp channel (rsp_valid/rsp_ready/rsp_item) returns exactly one result
//   per item, in order: popped word, status and the stack touched.
//   csr channel (csr_valid/csr_ready/csr_data) writes the per-stack capacity;
//   csr_ready is always high; the user makes writes while no item is in flight (unchecked).
// Timing:
//   one item per cycle is sustained while rsp_ready is high. The fill counts are
//   updated and the plate memory is written or read in the accept cycle; the
//   memory's registered read data and a result register follow.
// Reset clears all fill counts (every stack empty), sets the capacity to 16
// and empties the pipeline; the plate memory is not cleared.
// A stalled receiver holds the result register; one more item is taken into
// the middle stage, then req_ready drops until the result is taken.
module bank_of_stacks_leftmost_fill_top #(
   parameter int NUM_STACKS   = 16,
   parameter int MAX_CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  boslf_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output boslf_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [4:0]        csr_data
);

   localparam int SW    = $clog2(NUM_STACKS);
   localparam int CW    = $clog2(MAX_CAPACITY + 1);
   localparam int CMPW  = (CW > 5) ? CW : 5;
   localparam int DEPTH = NUM_STACKS * MAX_CAPACITY;
   localparam int AW    = $clog2(DEPTH);

   typedef struct packed {
      logic       pop_ok;
      logic [1:0] status;
      logic [3:0] stack_touched;
   } s1_type;

   // state
   logic [4:0]    cap_ff, cap_in;
   logic [CW-1:0] fill_ff [NUM_STACKS];
   logic [CW-1:0] fill_in [NUM_STACKS];
   logic [31:0]   plate_mem [DEPTH];
   logic [31:0]   rd_ff;
   logic          s1_valid_ff, s1_valid_in;
   s1_type        s1_ff, s1_in;
   logic          out_valid_ff, out_valid_in;
   boslf_pkg::rsp_type out_item_ff, out_item_in;

   // decode signals
   logic [CMPW-1:0] cap_wide, cap_eff;
   logic [NUM_STACKS-1:0] not_full, not_empty;
   logic          push_found, pop_found;
   logic [SW-1:0] push_sel, pop_sel, sel;
   logic [8:0]    idx_wide, sel_wide;
   logic          idx_in_range;
   logic          do_push, do_pop;
   logic [1:0]    status_now;
   logic [CW-1:0] fill_sel, offset;
   logic [AW-1:0] addr;
   logic          req_fire, s1_move;

   // handshake
   assign csr_ready = 1'b1;
   assign s1_move   = !out_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || s1_move;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   // effective capacity, clamped to 1..MAX_CAPACITY
   always_comb begin
      cap_wide = CMPW'(cap_ff);
      if (cap_wide == '0) begin
         cap_eff = CMPW'(1);
      end else if (cap_wide > CMPW'(MAX_CAPACITY)) begin
         cap_eff = CMPW'(MAX_CAPACITY);
      end else begin
         cap_eff = cap_wide;
      end
   end

   // per-stack flags
   always_comb begin
      for (int s = 0; s < NUM_STACKS; s++) begin
         not_full[s]  = CMPW'(fill_ff[s]) < cap_eff;
         not_empty[s] = fill_ff[s] != '0;
      end
   end

   // leftmost stack with room
   always_comb begin
      push_found = 1'b0;
      push_sel   = '0;
      for (int s = NUM_STACKS - 1; s >= 0; s--) begin
         if (not_full[s]) begin
            push_found = 1'b1;
            push_sel   = SW'(s);
         end
      end
   end

   // rightmost nonempty stack
   always_comb begin
      pop_found = 1'b0;
      pop_sel   = '0;
      for (int s = 0; s < NUM_STACKS; s++) begin
         if (not_empty[s]) begin
            pop_found = 1'b1;
            pop_sel   = SW'(s);
         end
      end
   end

   // operation decode
   always_comb begin
      idx_wide     = 9'(req_item.stack_index);
      idx_in_range = idx_wide < 9'(NUM_STACKS);
      sel          = '0;
      do_push      = 1'b0;
      do_pop       = 1'b0;
      status_now   = boslf_pkg::ST_DONE;
      unique case (req_item.opcode)
         boslf_pkg::OP_PUSH: begin
            sel = push_sel;
            if (push_found) begin
               do_push = 1'b1;
            end else begin
               status_now = boslf_pkg::ST_FULL;
            end
         end
         boslf_pkg::OP_POP: begin
            sel = pop_sel;
            if (pop_found) begin
               do_pop = 1'b1;
            end else begin
               status_now = boslf_pkg::ST_EMPTY;
            end
         end
         boslf_pkg::OP_POP_AT: begin
            if (idx_in_range) begin
               sel = idx_wide[SW-1:0];
            end
            if (idx_in_range && not_empty[idx_wide[SW-1:0]]) begin
               do_pop = 1'b1;
            end else begin
               status_now = boslf_pkg::ST_EMPTY;
            end
         end
         default: begin
            status_now = boslf_pkg::ST_DONE;
         end
      endcase
   end

   // plate address of the selected stack top
   always_comb begin
      fill_sel = fill_ff[sel];
      offset   = do_pop ? (fill_sel - CW'(1)) : fill_sel;
      addr     = AW'(sel) * AW'(MAX_CAPACITY) + AW'(offset);
      sel_wide = 9'(sel);
   end

   // next fill counts
   always_comb begin
      for (int s = 0; s < NUM_STACKS; s++) begin
         fill_in[s] = fill_ff[s];
      end
      if (req_fire && do_push) begin
         fill_in[sel] = fill_sel + CW'(1);
      end else if (req_fire && do_pop) begin
         fill_in[sel] = fill_sel - CW'(1);
      end
   end

   // capacity register
   always_comb begin
      cap_in = csr_valid ? csr_data : cap_ff;
   end

   // middle stage and result register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (req_fire) begin
         s1_valid_in         = 1'b1;
         s1_in.pop_ok        = do_pop;
         s1_in.status        = status_now;
         s1_in.stack_touched = (do_push || do_pop) ? sel_wide[3:0] : 4'd0;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (s1_move) begin
         out_valid_in              = s1_valid_ff;
         out_item_in.pop_value     = s1_ff.pop_ok ? rd_ff : 32'd0;
         out_item_in.status        = s1_ff.status;
         out_item_in.stack_touched = s1_ff.stack_touched;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= boslf_pkg::CAP_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int s = 0; s < NUM_STACKS; s++) begin
            fill_ff[s] <= '0;
         end
      end else begin
         cap_ff       <= cap_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         for (int s = 0; s < NUM_STACKS; s++) begin
            fill_ff[s] <= fill_in[s];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      out_item_ff <= out_item_in;
   end

   // plate memory, at most one access per item
   always_ff @(posedge clock) begin
      if (req_fire && do_push) begin
         plate_mem[addr] <= req_item.push_value;
      end
      if (req_fire && do_pop) begin
         rd_ff <= plate_mem[addr];
      end
   end

endmodule

[hdl/boslf_checker.sv]
// port checker for the stack bank, bound to the top level
`include "bank_of_stacks_leftmost_fill_top_macros.svh"

module boslf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input boslf_pkg::rsp_type rsp_item
);

   logic out_stalled;
   logic in_stalled;
   logic rsp_failed;
   logic rsp_fields_zero;

   // port conditions used by the checks
   assign out_stalled     = rsp_valid && !rsp_ready;
   assign in_stalled      = req_valid && !req_ready;
   assign rsp_failed      = rsp_valid && rsp_item.status != boslf_pkg::ST_DONE;
   assign rsp_fields_zero = rsp_item.pop_value == 32'd0 && rsp_item.stack_touched == 4'd0;

   // a stalled result stays valid
   `BOSLF_ASSERT_NEXT(a_rsp_hold, clock, reset, out_stalled, rsp_valid, "result dropped")

   // a stalled result keeps its payload
   `BOSLF_ASSERT_NEXT(a_item_hold, clock, reset, out_stalled, $stable(rsp_item), "result changed")

   // reset empties the pipeline
   `BOSLF_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   // failed operations carry no word and no stack
   `BOSLF_ASSERT_NOW(a_fail_zero, clock, reset, rsp_failed, rsp_fields_zero, "payload on failure")

   // the input only stalls behind a stalled result
   `BOSLF_ASSERT_NOW(a_input_stall, clock, reset, in_stalled, out_stalled, "needless input stall")

endmodule

bind bank_of_stacks_leftmost_fill_top boslf_checker u_boslf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

[verif/tb_top.sv]
// testbench of the plate stack bank: directed and random push and pop items checked against a predictor
module tb_top;

   localparam int NUM_STACKS   = 16;
   localparam int MAX_CAPACITY = 16;

   // opcode that the block leaves without effect
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic               clock;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   boslf_pkg::req_type req_item    = '0;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   boslf_pkg::rsp_type rsp_item;
   logic               csr_valid   = 1'b0;
   logic               csr_ready;
   logic [4:0]         csr_data    = '0;

   // predicted bank contents and capacity register
   logic [31:0] plate_mem [NUM_STACKS][MAX_CAPACITY];
   int          stack_fill [NUM_STACKS];
   logic [4:0]  cap_reg = boslf_pkg::CAP_RESET;

   boslf_pkg::req_type pending_items [$];
   boslf_pkg::rsp_type expected_rsps [$];
   boslf_pkg::rsp_type predicted;
   boslf_pkg::rsp_type oldest;

   logic req_taken = 1'b0;
   int   gap_left = 0;
   int   burst_left = 4;
   int   stall_request = 0;
   int   long_hold_left = 0;
   int   rx_cycle = 0;
   int   error_count = 0;
   int   items_taken = 0;
   int   pushes_stored = 0;
   int   pushes_dropped = 0;
   int   pops_with_word = 0;
   int   pops_found_none = 0;
   int   cap_writes = 0;

   bank_of_stacks_leftmost_fill_top #(
      .NUM_STACKS   (NUM_STACKS),
      .MAX_CAPACITY (MAX_CAPACITY)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      for (int s = 0; s < NUM_STACKS; s++) begin
         stack_fill[s] = 0;
      end
   end

   // remove the top word of one stack
   function automatic boslf_pkg::rsp_type take_top_plate(input int s);
      boslf_pkg::rsp_type res;
      res = '0;
      if (stack_fill[s] == 0) begin
         res.status = boslf_pkg::ST_EMPTY;
      end else begin
         stack_fill[s]     = stack_fill[s] - 1;
         res.pop_value     = plate_mem[s][stack_fill[s]];
         res.status        = boslf_pkg::ST_DONE;
         res.stack_touched = 4'(s);
      end
      return res;
   endfunction

   // next state of the bank and the result of one item
   function automatic boslf_pkg::rsp_type plate_bank_step(input boslf_pkg::req_type item);
      boslf_pkg::rsp_type res;
      int                 cap_eff;
      bit                 found;
      res   = '0;
      found = 1'b0;
      cap_eff = (cap_reg == 0) ? 1 : ((cap_reg > MAX_CAPACITY) ? MAX_CAPACITY : int'(cap_reg));
      unique case (item.opcode)
         boslf_pkg::OP_PUSH: begin
            for (int s = 0; s < NUM_STACKS; s++) begin
               if (!found && stack_fill[s] < cap_eff) begin
                  plate_mem[s][stack_fill[s]] = item.push_value;
                  stack_fill[s]     = stack_fill[s] + 1;
                  res.status        = boslf_pkg::ST_DONE;
                  res.stack_touched = 4'(s);
                  found = 1'b1;
               end
            end
            if (!found) begin
               res.status = boslf_pkg::ST_FULL;
            end
         end
         boslf_pkg::OP_POP: begin
            res.status = boslf_pkg::ST_EMPTY;
            for (int s = NUM_STACKS - 1; s >= 0; s--) begin
               if (!found && stack_fill[s] != 0) begin
                  res   = take_top_plate(s);
                  found = 1'b1;
               end
            end
         end
         boslf_pkg::OP_POP_AT: begin
            res = take_top_plate(int'(item.stack_index));
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic boslf_pkg::req_type make_op(input logic [1:0] op,
                                                  input logic [31:0] val,
                                                  input logic [3:0] idx);
      boslf_pkg::req_type item;
      item.opcode      = op;
      item.push_value  = val;
      item.stack_index = idx;
      return item;
   endfunction

   // append one item to the sender queue
   task automatic add_item(input logic [1:0] op, input logic [31:0] val,
                           input logic [3:0] idx);
      pending_items = {pending_items, make_op(op, val, idx)};
   endtask

   // sender: bursts of items with random gaps, driven on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the item until it is taken
      end else if (gap_left > 0) begin
         gap_left = gap_left - 1;
         req_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
         req_item  <= pending_items.pop_front();
         req_valid <= 1'b1;
         burst_left = burst_left - 1;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8);
            gap_left   = $urandom_range(0, 6);
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: stall pattern by window, plus long holds on request
   always @(negedge clock) begin
      if (stall_request > 0) begin
         long_hold_left = stall_request;
         stall_request  = 0;
      end
      rx_cycle = rx_cycle + 1;
      if (long_hold_left > 0) begin
         long_hold_left = long_hold_left - 1;
         rsp_ready <= 1'b0;
      end else if ((rx_cycle / 48) % 3 == 0) begin
         rsp_ready <= 1'b1;
      end else if ((rx_cycle / 48) % 3 == 1) begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end else begin
         rsp_ready <= ($urandom_range(0, 2) == 0);
      end
   end

   // monitor: predict on each taken item, check each taken result
   always @(posedge clock) begin
      req_taken <= req_valid && req_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            cap_reg    = csr_data;
            cap_writes = cap_writes + 1;
         end
         if (req_valid && req_ready) begin
            predicted = plate_bank_step(req_item);
            expected_rsps = {expected_rsps, predicted};
            items_taken = items_taken + 1;
            if (req_item.opcode == boslf_pkg::OP_PUSH) begin
               if (predicted.status == boslf_pkg::ST_DONE) pushes_stored = pushes_stored + 1;
               else pushes_dropped = pushes_dropped + 1;
            end else if (req_item.opcode != OP_UNUSED) begin
               if (predicted.status == boslf_pkg::ST_DONE) pops_with_word = pops_with_word + 1;
               else pops_found_none = pops_found_none + 1;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               error_count = error_count + 1;
               if (error_count <= 10) begin
                  $display("unexpected result: value %h status %0d stack %0d",
                           rsp_item.pop_value, rsp_item.status, rsp_item.stack_touched);
               end
            end else begin
               oldest = expected_rsps.pop_front();
               if (rsp_item.pop_value !== oldest.pop_value ||
                   rsp_item.status !== oldest.status ||
                   rsp_item.stack_touched !== oldest.stack_touched) begin
                  error_count = error_count + 1;
                  if (error_count <= 10) begin
                     $display("mismatch: expected value %h status %0d stack %0d,",
                              oldest.pop_value, oldest.status, oldest.stack_touched);
                     $display("          got value %h status %0d stack %0d",
                              rsp_item.pop_value, rsp_item.status, rsp_item.stack_touched);
                  end
               end
            end
         end
      end
   end

   // wait until the bank has drained
   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (pending_items.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [4:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one random phase at a given capacity and push share
   task automatic run_phase(input logic [4:0] cap, input int n_items, input int push_pct,
                            input int hold);
      int          r;
      logic [1:0]  op;
      logic [3:0]  idx;
      write_capacity(cap);
      if (hold > 0) begin
         @(posedge clock);
         stall_request = hold;
      end
      for (int i = 0; i < n_items; i++) begin
         r = $urandom_range(0, 99);
         if (r < push_pct) op = boslf_pkg::OP_PUSH;
         else if (r >= 97) op = OP_UNUSED;
         else op = $urandom_range(0, 1) ? boslf_pkg::OP_POP : boslf_pkg::OP_POP_AT;
         idx = $urandom_range(0, 1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
         add_item(op, $urandom, idx);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty pops, unused opcode, fill every stack at capacity one
      write_capacity(5'd1);
      add_item(boslf_pkg::OP_POP, 32'h0, 4'd0);
      add_item(boslf_pkg::OP_POP_AT, 32'hFFFF_FFFF, 4'd15);
      add_item(OP_UNUSED, 32'hFFFF_FFFF, 4'd15);
      add_item(boslf_pkg::OP_PUSH, 32'h0, 4'd15);
      add_item(boslf_pkg::OP_PUSH, 32'hFFFF_FFFF, 4'd0);
      for (int i = 0; i < 14; i++) begin
         add_item(boslf_pkg::OP_PUSH, $urandom, 4'($urandom_range(0, 15)));
      end
      // every stack full: push is dropped
      add_item(boslf_pkg::OP_PUSH, 32'hA5A5_5A5A, 4'd7);
      add_item(boslf_pkg::OP_POP_AT, 32'h0, 4'd0);
      add_item(boslf_pkg::OP_POP_AT, 32'h0, 4'd15);
      add_item(boslf_pkg::OP_POP, 32'h0, 4'd0);
      add_item(boslf_pkg::OP_PUSH, 32'h1234_5678, 4'd0);

      // random phases: out-of-range capacities, lowered capacity, long receiver holds
      run_phase(5'd0, 60, 60, 0);
      run_phase(5'd31, 80, 85, 60);
      run_phase(5'd3, 60, 50, 0);
      run_phase(5'd16, 70, 90, 0);
      run_phase(5'd17, 60, 40, 80);
      run_phase(5'd2, 60, 70, 0);
      run_phase(5'($urandom_range(1, 16)), 60, 55, 0);
      run_phase(5'd5, 60, 75, 0);
      run_phase(5'd1, 50, 30, 0);
      run_phase(5'd16, 60, 20, 0);

      wait_idle();
      $display("covered %0d items over %0d capacity writes: %0d pushes stored, %0d dropped",
               items_taken, cap_writes, pushes_stored, pushes_dropped);
      $display("pops returning a word %0d, pops finding nothing %0d, failures %0d",
               pops_with_word, pops_found_none, error_count);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("[bank_of_stacks_leftmost_fill_top] OK");
      end else begin
         $display("[bank_of_stacks_leftmost_fill_top] ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("[bank_of_stacks_leftmost_fill_top] ERROR");
      $finish;
   end

endmodule
